@@ design/sscd_pkg.sv @@
// shared constants, word kind codes and the character decoder
// for the seven-segment display scanner; no dependencies
package sscd_pkg;

    localparam int DIGITS_DEF = 8;

    localparam int SEG_W  = 8;
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int ON_W   = 16;
    localparam int GAP_W  = 8;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 1;

    localparam logic [ON_W-1:0]  ON_TICKS_RST  = 16'd100;
    localparam logic [GAP_W-1:0] GAP_TICKS_RST = 8'd5;

    localparam logic [CIDX_W-1:0] REG_ON_TICKS  = 1'd0;
    localparam logic [CIDX_W-1:0] REG_GAP_TICKS = 1'd1;

    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_BEL  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;

    localparam logic [SEG_W-1:0] DP_BIT   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_DASH = 8'h40;

    localparam logic [SEG_W-1:0] HEX_GLYPH [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    // hex digits in either case and minus; anything else is blank
    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        logic [SEG_W-1:0] g;
        g = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            g = HEX_GLYPH[4'(c - 8'h30)];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            g = HEX_GLYPH[4'(c - 8'h37)];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            g = HEX_GLYPH[4'(c - 8'h57)];
        end else if (c == CH_DASH) begin
            g = SEG_DASH;
        end
        return g;
    endfunction

endpackage

@@ design/sscd_buffer.sv @@
// digit code buffer with push and string fill; depends on sscd_pkg
// presents the buffer after the word's update for the result register
module sscd_buffer
    import sscd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         upd_en,
    input  logic [KIND_W-1:0]            kind,
    input  logic [CHAR_W-1:0]            char_code,
    output logic [DIGITS-1:0][SEG_W-1:0] codes_next
);

    localparam int POS_W = $clog2(DIGITS + 1);

    logic [DIGITS-1:0][SEG_W-1:0] codes_reg;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [SEG_W-1:0]             glyph;
    logic [POS_W-1:0]             pos_prev;
    logic                         pos_full;

    assign glyph    = glyph_of(char_code);
    assign pos_prev = pos_reg - POS_W'(1);
    assign pos_full = (pos_reg >= POS_W'(DIGITS));

    always_comb begin
        codes_next = codes_reg;
        pos_next   = pos_reg;
        unique case (kind)
            KIND_PUSH: begin
                if (char_code == CH_CR || char_code == CH_LF) begin
                    codes_next = '0;
                end else if (char_code != CH_BEL) begin
                    for (int i = DIGITS - 1; i > 0; i--) begin
                        codes_next[i] = codes_reg[i-1];
                    end
                    codes_next[0] = glyph;
                end
            end
            KIND_BEGIN: begin
                pos_next = '0;
            end
            KIND_CHAR: begin
                if (char_code == CH_DOT) begin
                    // dot marks the digit written last
                    for (int i = 0; i < DIGITS; i++) begin
                        if (pos_reg != '0 && pos_prev == POS_W'(i)) begin
                            codes_next[i] = codes_reg[i] | DP_BIT;
                        end
                    end
                end else if (!pos_full) begin
                    for (int i = 0; i < DIGITS; i++) begin
                        if (pos_reg == POS_W'(i)) begin
                            codes_next[i] = glyph;
                        end
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            KIND_END: begin
                // blank what the string did not reach
                for (int i = 0; i < DIGITS; i++) begin
                    if (pos_reg != '0 && POS_W'(i) >= pos_reg) begin
                        codes_next[i] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg <= '0;
            pos_reg   <= '0;
        end else if (upd_en) begin
            codes_reg <= codes_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

@@ design/sscd_scan.sv @@
// scan sequencer: lit and gap phases counted in ticks; depends on sscd_pkg
// holds the timing registers written through the configuration port
module sscd_scan
    import sscd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF,
    parameter int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              tick_en,
    output logic [DIG_W-1:0]  scan_digit,
    output logic              scan_in_gap
);

    logic [ON_W-1:0]  on_ticks_reg;
    logic [GAP_W-1:0] gap_ticks_reg;
    logic [ON_W-1:0]  count_reg, count_next;
    logic [DIG_W-1:0] digit_reg, digit_next, digit_inc;
    logic             gap_reg, gap_next;
    logic [ON_W-1:0]  on_len;
    logic [ON_W:0]    count_p1;
    logic             lit_done, gap_done;

    assign on_len    = (on_ticks_reg == '0) ? ON_W'(1) : on_ticks_reg;
    assign count_p1  = {1'b0, count_reg} + (ON_W+1)'(1);
    assign lit_done  = (count_p1 >= {1'b0, on_len});
    assign gap_done  = (count_p1 >= (ON_W+1)'(gap_ticks_reg));
    assign digit_inc = (digit_reg == DIG_W'(DIGITS - 1)) ? '0 : digit_reg + DIG_W'(1);

    always_comb begin
        count_next = count_reg + ON_W'(1);
        digit_next = digit_reg;
        gap_next   = gap_reg;
        if (!gap_reg) begin
            if (lit_done) begin
                count_next = '0;
                if (gap_ticks_reg != '0) begin
                    gap_next = 1'b1;
                end else begin
                    digit_next = digit_inc;
                end
            end
        end else if (gap_done) begin
            count_next = '0;
            gap_next   = 1'b0;
            digit_next = digit_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_ticks_reg  <= ON_TICKS_RST;
            gap_ticks_reg <= GAP_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ON_TICKS:  on_ticks_reg  <= cfg_wdata[ON_W-1:0];
                REG_GAP_TICKS: gap_ticks_reg <= cfg_wdata[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            digit_reg <= '0;
            gap_reg   <= 1'b0;
        end else if (tick_en) begin
            count_reg <= count_next;
            digit_reg <= digit_next;
            gap_reg   <= gap_next;
        end
    end

    assign scan_digit  = digit_reg;
    assign scan_in_gap = gap_reg;

endmodule

@@ design/seven_segment_char_display_scanner.sv @@
// top level of the seven-segment display scanner: buffer, scan sequencer
// and result register; depends on sscd_pkg, sscd_buffer, sscd_scan
//
// One word in, one result word out. Every accepted word updates the digit
// buffer and the scan state in the cycle it is accepted, and its result
// lands in the output register on the same edge. A new word is taken
// whenever the output register is empty or is being drained, so the block
// sustains one word per clock under no backpressure. The result shows the
// buffer after the word's update and the scan phase before a tick word
// advances it. Tick words step the scan: each digit is lit for on_ticks
// ticks (0 acts as 1), then all digits are dark for gap_ticks ticks. Push
// words shift the buffer up one place and enter at digit 0; BEL pulses
// bell, CR or LF clear the display. String words fill from digit 0 up, a
// dot sets the decimal point of the digit written last, and the end word
// blanks the digits the string did not reach. The user must write timing
// registers via the plain write port while idle; it is not enforced.
module seven_segment_char_display_scanner
    import sscd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [CHAR_W-1:0] s_char_code,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SEG_W-1:0]  m_segments,
    output logic [7:0]        m_digit_enable,
    output logic              m_bell
);

    localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                         accept;
    logic [DIGITS-1:0][SEG_W-1:0] codes_next;
    logic [DIG_W-1:0]             scan_digit;
    logic                         scan_in_gap;
    logic [SEG_W-1:0]             seg_next;
    logic [7:0]                   en_next;
    logic                         bell_next;

    logic             m_valid_reg;
    logic [SEG_W-1:0] m_segments_reg;
    logic [7:0]       m_digit_enable_reg;
    logic             m_bell_reg;

    // output register empty or draining this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sscd_buffer #(
        .DIGITS(DIGITS)
    ) u_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (accept),
        .kind      (s_kind),
        .char_code (s_char_code),
        .codes_next(codes_next)
    );

    // scan only moves on tick words
    sscd_scan #(
        .DIGITS(DIGITS),
        .DIG_W (DIG_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .tick_en    (accept && s_kind == KIND_TICK),
        .scan_digit (scan_digit),
        .scan_in_gap(scan_in_gap)
    );

    // dark during the gap; enables above the eighth digit read as zero
    always_comb begin
        seg_next = '0;
        en_next  = '0;
        if (!scan_in_gap) begin
            seg_next = codes_next[scan_digit];
            for (int i = 0; i < 8; i++) begin
                en_next[i] = (int'(scan_digit) == i);
            end
        end
    end

    assign bell_next = (s_kind == KIND_PUSH) && (s_char_code == CH_BEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_segments_reg     <= seg_next;
            m_digit_enable_reg <= en_next;
            m_bell_reg         <= bell_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_segments     = m_segments_reg;
    assign m_digit_enable = m_digit_enable_reg;
    assign m_bell         = m_bell_reg;

endmodule
